// ===== rtl/scan_line_ssid_rssi_extractor_unit_defines.svh =====
// assertion macros for the scan line ssid/rssi extractor
// used by the top level only, needs no other file
`ifndef SCAN_LINE_SSID_RSSI_EXTRACTOR_UNIT_DEFINES_SVH
`define SCAN_LINE_SSID_RSSI_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLSRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slsre: same-cycle check failed");
// next-cycle implication
`define SLSRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slsre: next-cycle check failed");
`else
`define SLSRE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SLSRE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/slsre_pkg.sv =====
// shared types and constants of the scan line ssid/rssi extractor
// no dependencies
package slsre_pkg;

  localparam int unsigned NUM_SSID_REGS = 4;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned ACC_W         = 17;
  localparam int unsigned RSSI_W        = 16;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_ADDR_W    = 6;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;

  // register index (address bits 5:3)
  typedef enum logic [2:0] {
    REG_SSID_0_7   = 3'd0,
    REG_SSID_8_15  = 3'd1,
    REG_SSID_16_23 = 3'd2,
    REG_SSID_24_31 = 3'd3,
    REG_SSID_LEN   = 3'd4
  } cfg_reg_e;

  // per-byte control handed from the parser to the match cells
  typedef struct packed {
    logic       take;   // byte enters the current line
    logic       clear;  // current line closes this cycle
    logic [7:0] data;
  } byte_ctrl_t;

  typedef struct packed {
    logic                     found;
    logic signed [RSSI_W-1:0] rssi;
  } result_t;

endpackage

// ===== rtl/slsre_match_cell.sv =====
// one cell of the ssid matcher chain: holds "ssid prefix up to here matched"
// depends on slsre_pkg
module slsre_match_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slsre_pkg::byte_ctrl_t  ctrl_i,
  input  logic [7:0]             ssid_byte_i,
  input  logic                   prev_match_i,
  output logic                   hit_o,
  output logic                   match_o
);

  logic match_d, match_q;

  // prefix one shorter matched on the previous byte and this byte matches
  assign hit_o = ctrl_i.take && prev_match_i && (ctrl_i.data == ssid_byte_i);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.clear) begin
      match_d = 1'b0;
    end else if (ctrl_i.take) begin
      match_d = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

// ===== rtl/slsre_field_parser.sv =====
// line, field and number parser with the per-report result latch
// depends on slsre_pkg
module slsre_field_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  logic                   ssid_hit_i,
  output slsre_pkg::byte_ctrl_t  ctrl_o,
  output logic                   res_valid_o,
  output slsre_pkg::result_t     res_o
);

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  localparam logic [slsre_pkg::ACC_W-1:0] ACC_SAT = slsre_pkg::ACC_W'(32768);
  localparam logic [slsre_pkg::ACC_W-1:0] POS_MAX = slsre_pkg::ACC_W'(32767);

  logic       nonempty_q, nonempty_d;
  logic       has_ssid_q, has_ssid_d;
  logic [1:0] fields_q, fields_d;
  logic       field_bytes_q, field_bytes_d;
  phase_e     phase_q, phase_d;
  logic [slsre_pkg::ACC_W-1:0] acc_q, acc_d;
  logic       neg_q, neg_d;
  logic       third_q, third_d;
  logic       latched_q, latched_d;
  logic       lfound_q, lfound_d;
  logic [slsre_pkg::RSSI_W-1:0] lrssi_q, lrssi_d;
  logic       ended_q, ended_d;

  logic       is_nul, is_nl, is_digit, is_space, is_sign;
  logic [19:0] acc_mul;
  logic [slsre_pkg::ACC_W-1:0] acc_step, acc_neg;
  logic [slsre_pkg::RSSI_W-1:0] rssi_c;
  logic       close_ok, found_c;
  logic [slsre_pkg::RSSI_W-1:0] lrssi_c;

  assign is_nul   = (byte_i == slsre_pkg::CH_NUL);
  assign is_nl    = (byte_i == slsre_pkg::CH_NEWLINE);
  assign is_digit = (byte_i >= slsre_pkg::CH_DIGIT0) && (byte_i <= slsre_pkg::CH_DIGIT9);
  assign is_space = (byte_i == slsre_pkg::CH_SPACE) ||
                    ((byte_i >= slsre_pkg::CH_TAB) && (byte_i <= slsre_pkg::CH_CR));
  assign is_sign  = (byte_i == slsre_pkg::CH_PLUS) || (byte_i == slsre_pkg::CH_MINUS);

  assign ctrl_o.data  = byte_i;
  assign ctrl_o.take  = accept_i && !ended_q && !is_nul && !is_nl;
  assign ctrl_o.clear = accept_i && (last_i || (!ended_q && (is_nul || is_nl)));

  // times ten as shift and add, then digit, saturating at 32768
  assign acc_mul  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {16'd0, byte_i[3:0]};
  assign acc_step = (acc_mul > 20'(ACC_SAT)) ? ACC_SAT : acc_mul[slsre_pkg::ACC_W-1:0];

  always_comb begin
    nonempty_d    = nonempty_q;
    has_ssid_d    = has_ssid_q;
    fields_d      = fields_q;
    field_bytes_d = field_bytes_q;
    phase_d       = phase_q;
    acc_d         = acc_q;
    neg_d         = neg_q;
    third_d       = third_q;

    if (ctrl_o.take) begin
      nonempty_d = 1'b1;
      has_ssid_d = has_ssid_q || ssid_hit_i;
      if (byte_i == slsre_pkg::CH_COMMA) begin
        if (field_bytes_q) begin
          if (fields_q == 2'd2) begin
            phase_d = PH_DONE;
          end else begin
            fields_d = fields_q + 2'd1;
          end
        end
        field_bytes_d = 1'b0;
      end else begin
        field_bytes_d = 1'b1;
        if ((fields_q == 2'd2) && (phase_q != PH_DONE)) begin
          third_d = 1'b1;
          unique case (phase_q)
            PH_LEAD: begin
              if (is_space) begin
                phase_d = PH_LEAD;
              end else if (is_sign) begin
                neg_d   = (byte_i == slsre_pkg::CH_MINUS);
                phase_d = PH_DIGITS;
              end else if (is_digit) begin
                phase_d = PH_DIGITS;
                acc_d   = acc_step;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                acc_d = acc_step;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // value of the line as it closes
  assign acc_neg = slsre_pkg::ACC_W'(0) - acc_d;
  assign rssi_c  = neg_d ? acc_neg[slsre_pkg::RSSI_W-1:0] :
                   ((acc_d > POS_MAX) ? POS_MAX[slsre_pkg::RSSI_W-1:0]
                                      : acc_d[slsre_pkg::RSSI_W-1:0]);

  assign close_ok = ctrl_o.clear && nonempty_d && has_ssid_d && !latched_q;
  assign found_c  = close_ok ? third_d : lfound_q;
  assign lrssi_c  = close_ok ? (third_d ? rssi_c : '0) : lrssi_q;

  assign res_valid_o = accept_i && last_i;
  assign res_o.found = found_c;
  assign res_o.rssi  = found_c ? $signed(lrssi_c) : '0;

  always_comb begin
    latched_d = latched_q || close_ok;
    lfound_d  = found_c;
    lrssi_d   = lrssi_c;
    ended_d   = ended_q || (accept_i && is_nul);
    if (accept_i && last_i) begin
      latched_d = 1'b0;
      lfound_d  = 1'b0;
      lrssi_d   = '0;
      ended_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q    <= 1'b0;
      has_ssid_q    <= 1'b0;
      fields_q      <= 2'd0;
      field_bytes_q <= 1'b0;
      phase_q       <= PH_LEAD;
      acc_q         <= '0;
      neg_q         <= 1'b0;
      third_q       <= 1'b0;
      latched_q     <= 1'b0;
      lfound_q      <= 1'b0;
      lrssi_q       <= '0;
      ended_q       <= 1'b0;
    end else begin
      if (ctrl_o.clear) begin
        nonempty_q    <= 1'b0;
        has_ssid_q    <= 1'b0;
        fields_q      <= 2'd0;
        field_bytes_q <= 1'b0;
        phase_q       <= PH_LEAD;
        acc_q         <= '0;
        neg_q         <= 1'b0;
        third_q       <= 1'b0;
      end else begin
        nonempty_q    <= nonempty_d;
        has_ssid_q    <= has_ssid_d;
        fields_q      <= fields_d;
        field_bytes_q <= field_bytes_d;
        phase_q       <= phase_d;
        acc_q         <= acc_d;
        neg_q         <= neg_d;
        third_q       <= third_d;
      end
      latched_q <= latched_d;
      lfound_q  <= lfound_d;
      lrssi_q   <= lrssi_d;
      ended_q   <= ended_d;
    end
  end

endmodule

// ===== rtl/scan_line_ssid_rssi_extractor_unit.sv =====
// top level of the scan line ssid/rssi extractor
// depends on slsre_pkg, slsre_match_cell, slsre_field_parser and the defines header
//
// Takes a scan report one byte per word and one word per clock, with no gaps
// needed. A row of MAX_SSID_BYTES match cells, one per ssid byte, shifts a
// "prefix matched" flag along with every byte, so the ssid is found anywhere
// in a line without a byte window or a wide compare. The parser beside it
// tracks comma fields of the line and reads the third one like atoi,
// saturating to 16 bits. The first non-empty line holding the ssid decides;
// its value comes out as one word in the cycle after the byte flagged
// end_of_report is taken. A zero byte ends the report content. The result
// register frees itself as it is taken, so input only stalls while a result
// sits stalled at the output. Critical path: the times-ten digit step, the
// negate and the result select. No clearing pass after reset.
// Configuration (APB, 64-bit data, register i at byte address 8*i) may only
// be written while no report is in flight.
module scan_line_ssid_rssi_extractor_unit #(
  parameter int unsigned MAX_SSID_BYTES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // byte input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          report_byte_i,
  input  logic                                end_of_report_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic signed [slsre_pkg::RSSI_W-1:0] rssi_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slsre_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [slsre_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [slsre_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  `include "scan_line_ssid_rssi_extractor_unit_defines.svh"

  // ssid registers and length
  logic [slsre_pkg::CFG_DATA_W-1:0] ssid_q [slsre_pkg::NUM_SSID_REGS];
  logic [slsre_pkg::LEN_W-1:0]      ssid_len_q;
  logic                             cfg_wr;
  slsre_pkg::cfg_reg_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = slsre_pkg::cfg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < slsre_pkg::NUM_SSID_REGS; r++) begin
        ssid_q[r] <= '0;
      end
      ssid_len_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        slsre_pkg::REG_SSID_0_7:   ssid_q[0]  <= pwdata;
        slsre_pkg::REG_SSID_8_15:  ssid_q[1]  <= pwdata;
        slsre_pkg::REG_SSID_16_23: ssid_q[2]  <= pwdata;
        slsre_pkg::REG_SSID_24_31: ssid_q[3]  <= pwdata;
        slsre_pkg::REG_SSID_LEN:   ssid_len_q <= pwdata[slsre_pkg::LEN_W-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      slsre_pkg::REG_SSID_0_7:   prdata = ssid_q[0];
      slsre_pkg::REG_SSID_8_15:  prdata = ssid_q[1];
      slsre_pkg::REG_SSID_16_23: prdata = ssid_q[2];
      slsre_pkg::REG_SSID_24_31: prdata = ssid_q[3];
      slsre_pkg::REG_SSID_LEN:
        prdata = {{(slsre_pkg::CFG_DATA_W-slsre_pkg::LEN_W){1'b0}}, ssid_len_q};
      default:                   prdata = '0;
    endcase
  end

  // length clamped to the cells present
  logic [slsre_pkg::LEN_W-1:0] len_eff;
  assign len_eff = (ssid_len_q > slsre_pkg::LEN_W'(MAX_SSID_BYTES)) ?
                   slsre_pkg::LEN_W'(MAX_SSID_BYTES) : ssid_len_q;

  // handshake: input waits only while a finished word is held at the output
  logic in_acc;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  slsre_pkg::byte_ctrl_t ctrl;
  slsre_pkg::result_t    res;
  logic                  res_valid;
  logic                  ssid_hit;
  logic                  sel_hit;

  logic [MAX_SSID_BYTES-1:0] hit_vec;
  logic [MAX_SSID_BYTES-1:0] match_vec;

  // the matcher row: cell j says the first j+1 ssid bytes end at this byte
  for (genvar j = 0; j < MAX_SSID_BYTES; j++) begin : g_cell
    logic prev_match;
    if (j == 0) begin : g_head
      assign prev_match = 1'b1;
    end else begin : g_link
      assign prev_match = match_vec[j-1];
    end
    slsre_match_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ssid_byte_i (ssid_q[j/8][8*(j%8) +: 8]),
      .prev_match_i(prev_match),
      .hit_o       (hit_vec[j]),
      .match_o     (match_vec[j])
    );
  end

  // pick the cell at the configured length; empty ssid matches any byte
  always_comb begin
    sel_hit = 1'b0;
    for (int j = 0; j < MAX_SSID_BYTES; j++) begin
      if (len_eff == slsre_pkg::LEN_W'(j + 1)) begin
        sel_hit = hit_vec[j];
      end
    end
  end
  assign ssid_hit = sel_hit || ((len_eff == '0) && ctrl.take);

  slsre_field_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .byte_i     (report_byte_i),
    .last_i     (end_of_report_i),
    .ssid_hit_i (ssid_hit),
    .ctrl_o     (ctrl),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // output register
  logic                     out_valid_q, out_valid_d;
  logic                     found_q;
  logic [slsre_pkg::RSSI_W-1:0] rssi_q;

  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      found_q <= res.found;
      rssi_q  <= res.rssi;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign rssi_o      = $signed(rssi_q);

  // checks
  `SLSRE_ASSERT_IMP(a_nofound_zero, clk_i, rst_ni, out_valid_o && !found_o, rssi_o == '0)
  `SLSRE_ASSERT_NXT(a_end_gives_word, clk_i, rst_ni, in_acc && end_of_report_i, out_valid_o)
  `SLSRE_ASSERT_NXT(a_cells_cleared, clk_i, rst_ni, in_acc && end_of_report_i, match_vec == '0)

endmodule

// ===== sim/scan_line_ssid_rssi_extractor_unit_test.sv =====
// testbench for scan_line_ssid_rssi_extractor_unit: streams scan reports byte by byte,
// predicts found/rssi per report in a behavioural model and checks every result word
// depends on slsre_pkg and the rtl of the extractor, nothing else
module scan_line_ssid_rssi_extractor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SSID_SLOTS   = 32;
  localparam int HOLD_CYCLES  = 300;   // one long output hold-off
  localparam int QUIET_LIMIT  = 3000;  // cycles with no word moving anywhere
  localparam int SETTLE_TICKS = 8;     // pause before a register write or the verdict

  // register index that decodes to nothing
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {ATOI_LEAD, ATOI_DIGITS, ATOI_DONE} atoi_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } scan_word_t;

  // dut ports
  logic                                clk_i;
  logic                                rst_ni          = 1'b0;
  logic                                in_valid_i      = 1'b0;
  logic                                in_stall_o;
  logic [7:0]                          report_byte_i   = '0;
  logic                                end_of_report_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i     = 1'b0;
  logic                                found_o;
  logic signed [slsre_pkg::RSSI_W-1:0] rssi_o;
  logic                                psel            = 1'b0;
  logic                                penable         = 1'b0;
  logic                                pwrite          = 1'b0;
  logic [slsre_pkg::CFG_ADDR_W-1:0]    paddr           = '0;
  logic [slsre_pkg::CFG_DATA_W-1:0]    pwdata          = '0;
  logic [slsre_pkg::CFG_DATA_W-1:0]    prdata;
  logic                                pready;

  scan_line_ssid_rssi_extractor_unit #(
    .MAX_SSID_BYTES(SSID_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .report_byte_i  (report_byte_i),
    .end_of_report_i(end_of_report_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .rssi_o         (rssi_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // ---------------------------------------------------------------------------
  // behavioural model: mirrored registers plus per-line and per-report state
  // ---------------------------------------------------------------------------
  logic [63:0]        ssid_cfg [4] = '{default: '0};
  logic [5:0]         ssid_len_cfg = '0;

  logic [7:0]         tail_bytes [SSID_SLOTS];  // newest byte of the line at index 0
  int                 tail_fill     = 0;        // bytes in the line, saturating
  bit                 line_matched  = 1'b0;
  int                 fields_seen   = 0;        // non-empty comma fields closed so far
  bit                 field_open    = 1'b0;
  atoi_phase_e        atoi_phase    = ATOI_LEAD;
  int unsigned        rssi_mag      = 0;
  bit                 rssi_neg      = 1'b0;
  bit                 third_open    = 1'b0;
  bit                 line_decided  = 1'b0;     // first matching line has spoken
  bit                 decided_found = 1'b0;
  logic signed [15:0] decided_rssi  = '0;
  bit                 report_over   = 1'b0;     // nul byte seen, rest is ignored

  slsre_pkg::result_t rssi_verdicts_q [$];   // expected result words, oldest first

  function automatic int ssid_span();
    return (ssid_len_cfg > SSID_SLOTS) ? SSID_SLOTS : int'(ssid_len_cfg);
  endfunction

  function automatic logic [7:0] ssid_char(int k);
    return 8'(ssid_cfg[k / 8] >> (8 * (k % 8)));
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == slsre_pkg::CH_SPACE || (b >= slsre_pkg::CH_TAB && b <= slsre_pkg::CH_CR);
  endfunction

  function automatic void clear_line_state();
    foreach (tail_bytes[k]) tail_bytes[k] = 8'h00;
    tail_fill    = 0;
    line_matched = 1'b0;
    fields_seen  = 0;
    field_open   = 1'b0;
    atoi_phase   = ATOI_LEAD;
    rssi_mag     = 0;
    rssi_neg     = 1'b0;
    third_open   = 1'b0;
  endfunction

  // only the first non-empty line holding the ssid latches a verdict
  function automatic void close_scan_line();
    if (tail_fill > 0 && line_matched && !line_decided) begin
      line_decided  = 1'b1;
      decided_found = third_open;
      if (!third_open) begin
        decided_rssi = '0;
      end else if (rssi_neg) begin
        decided_rssi = 16'(65536 - rssi_mag);
      end else begin
        decided_rssi = (rssi_mag > 32767) ? 16'sd32767 : 16'(rssi_mag);
      end
    end
    clear_line_state();
  endfunction

  // atoi on the third field: blanks, one sign, then digits up to the first non-digit
  function automatic void atoi_char(logic [7:0] b);
    bit is_digit;
    is_digit = (b >= slsre_pkg::CH_DIGIT0 && b <= slsre_pkg::CH_DIGIT9);
    if (atoi_phase == ATOI_LEAD) begin
      if (is_blank(b)) return;
      if (b == slsre_pkg::CH_PLUS || b == slsre_pkg::CH_MINUS) begin
        rssi_neg   = (b == slsre_pkg::CH_MINUS);
        atoi_phase = ATOI_DIGITS;
        return;
      end
      if (!is_digit) begin
        atoi_phase = ATOI_DONE;
        return;
      end
      atoi_phase = ATOI_DIGITS;
    end
    if (atoi_phase == ATOI_DIGITS) begin
      if (is_digit) begin
        rssi_mag = rssi_mag * 10 + (b - slsre_pkg::CH_DIGIT0);
        if (rssi_mag > 32768) rssi_mag = 32768;
      end else begin
        atoi_phase = ATOI_DONE;
      end
    end
  endfunction

  function automatic void line_char(logic [7:0] b);
    int len;
    bit same;
    len = ssid_span();
    for (int k = SSID_SLOTS - 1; k > 0; k--) tail_bytes[k] = tail_bytes[k - 1];
    tail_bytes[0] = b;
    if (tail_fill < SSID_SLOTS) tail_fill++;
    if (!line_matched && tail_fill >= len) begin
      same = 1'b1;
      for (int k = 0; k < len; k++)
        if (ssid_char(k) != tail_bytes[len - 1 - k]) same = 1'b0;
      line_matched = same;
    end
    if (b == slsre_pkg::CH_COMMA) begin
      // empty fields do not count
      if (field_open) begin
        if (fields_seen >= 2) atoi_phase = ATOI_DONE;
        else fields_seen++;
      end
      field_open = 1'b0;
    end else begin
      field_open = 1'b1;
      if (fields_seen >= 2 && atoi_phase != ATOI_DONE) begin
        third_open = 1'b1;
        atoi_char(b);
      end
    end
  endfunction

  function automatic bit take_report_byte(logic [7:0] b, logic last,
                                          output slsre_pkg::result_t r);
    r = '0;
    if (!report_over) begin
      if (b == slsre_pkg::CH_NUL) begin
        close_scan_line();
        report_over = 1'b1;
      end else if (b == slsre_pkg::CH_NEWLINE) begin
        close_scan_line();
      end else begin
        line_char(b);
      end
    end
    if (!last) return 1'b0;
    close_scan_line();
    r.found = decided_found;
    r.rssi  = decided_found ? decided_rssi : '0;
    line_decided  = 1'b0;
    decided_found = 1'b0;
    decided_rssi  = '0;
    report_over   = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // shared controls between the stimulus and the clocked processes
  // ---------------------------------------------------------------------------
  scan_word_t pending_words [$];  // words still to be offered by the driver
  scan_word_t draft_q [$];        // report under construction
  int         words_queued = 0;
  int         words_taken  = 0;
  int         mismatches   = 0;
  bit         idle_on      = 1'b1;  // random gaps on both channels
  bit         pressure_on  = 1'b0;  // asks the receiver for its one long hold-off

  // ---------------------------------------------------------------------------
  // driver: offers report words, holds a stalled word, inserts gap bursts
  // ---------------------------------------------------------------------------
  int         send_gap = 0;
  scan_word_t next_word;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      // the slot is free at this edge: idle, or the word on the bus was taken
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_valid_i      <= 1'b1;
        report_byte_i   <= next_word.ch;
        end_of_report_i <= next_word.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: short stall bursts, plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (pressure_on && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted input word, checks every result word
  // ---------------------------------------------------------------------------
  slsre_pkg::result_t predicted;
  slsre_pkg::result_t oldest;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // predict first so a same-edge result could still find its entry
      if (in_valid_i && !in_stall_o) begin
        words_taken++;
        if (take_report_byte(report_byte_i, end_of_report_i, predicted))
          rssi_verdicts_q.push_back(predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (rssi_verdicts_q.size() == 0) begin
          $error("result word with nothing expected: found %0d rssi %0d", found_o, rssi_o);
          mismatches++;
        end else begin
          oldest = rssi_verdicts_q.pop_front();
          if (found_o !== oldest.found) begin
            $error("found: expected %0d, got %0d", oldest.found, found_o);
            mismatches++;
          end
          if (rssi_o !== oldest.rssi) begin
            $error("rssi: expected %0d, got %0d", oldest.rssi, rssi_o);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog: a long stretch with no word moving on any port means a hang
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // configuration writes, apb setup then access phase
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // the register took the value at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      slsre_pkg::REG_SSID_0_7, slsre_pkg::REG_SSID_8_15,
      slsre_pkg::REG_SSID_16_23, slsre_pkg::REG_SSID_24_31: ssid_cfg[idx[1:0]] = val;
      slsre_pkg::REG_SSID_LEN: ssid_len_cfg = val[5:0];
      default: ;
    endcase
  endtask

  task automatic program_ssid(logic [255:0] name, logic [63:0] len);
    cfg_write(slsre_pkg::REG_SSID_0_7,   name[63:0]);
    cfg_write(slsre_pkg::REG_SSID_8_15,  name[127:64]);
    cfg_write(slsre_pkg::REG_SSID_16_23, name[191:128]);
    cfg_write(slsre_pkg::REG_SSID_24_31, name[255:192]);
    cfg_write(slsre_pkg::REG_SSID_LEN,   len);
  endtask

  // bytes past n are junk that the block must ignore
  function automatic logic [255:0] random_name(int n, bit printable);
    logic [255:0] name;
    logic [7:0]   c;
    for (int i = 0; i < SSID_SLOTS; i++) begin
      if (i >= n) c = 8'($urandom);
      else if (printable)
        do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == slsre_pkg::CH_COMMA);
      else c = 8'($urandom_range(1, 255));
      name[8 * i +: 8] = c;
    end
    return name;
  endfunction

  // wait until every word went in and every result came out, then let the block settle
  task automatic wait_drained();
    while (words_taken != words_queued || rssi_verdicts_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // report generation
  // ---------------------------------------------------------------------------
  task automatic draft_put(logic [7:0] c);
    draft_q.push_back(scan_word_t'{c, 1'b0});
  endtask

  task automatic draft_str(string s);
    foreach (s[i]) draft_put(s[i]);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = slsre_pkg::CH_SPACE;
      1:       c = 8'($urandom_range(8'h80, 8'hFF));
      default: do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == slsre_pkg::CH_COMMA);
    endcase
    return c;
  endfunction

  task automatic draft_text(int n);
    repeat (n) draft_put(text_char());
  endtask

  // signal field: blanks, optional sign, a few digits (sometimes too many), junk tail
  task automatic draft_number();
    int r;
    int nd;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(8, 13);
      draft_put(r == 8 ? slsre_pkg::CH_SPACE : 8'(r));
    end
    case ($urandom_range(0, 3))
      0:       draft_put(slsre_pkg::CH_PLUS);
      1:       draft_put(slsre_pkg::CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       nd = 0;
      1:       nd = $urandom_range(5, 7);
      default: nd = $urandom_range(1, 3);
    endcase
    repeat (nd) draft_put(8'(slsre_pkg::CH_DIGIT0 + $urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0) draft_text($urandom_range(1, 3));
  endtask

  // one scan line: ssid mostly in the second field, signal in the third
  task automatic draft_line(bit with_ssid, int n_fields);
    int ssid_at;
    ssid_at = -1;
    if (with_ssid)
      ssid_at = ($urandom_range(0, 3) == 0 || n_fields < 2) ? $urandom_range(0, n_fields - 1) : 1;
    if ($urandom_range(0, 7) == 0) draft_put(slsre_pkg::CH_COMMA);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) begin
        draft_put(slsre_pkg::CH_COMMA);
        if ($urandom_range(0, 4) == 0) draft_put(slsre_pkg::CH_COMMA);
      end
      if (f == ssid_at) begin
        draft_text($urandom_range(0, 2));
        for (int k = 0; k < ssid_span(); k++) draft_put(ssid_char(k));
        draft_text($urandom_range(0, 2));
      end else if (f == 2) begin
        draft_number();
      end else begin
        draft_text($urandom_range(1, 4));
      end
    end
    draft_put(slsre_pkg::CH_NEWLINE);
  endtask

  task automatic flush_draft();
    foreach (draft_q[i]) pending_words.push_back(draft_q[i]);
    words_queued += draft_q.size();
    draft_q.delete();
  endtask

  task automatic close_report(logic [7:0] c);
    draft_q.push_back(scan_word_t'{c, 1'b1});
    flush_draft();
  endtask

  task automatic queue_report();
    logic [7:0] tail;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: draft_line(1'b1, $urandom_range(3, 5));
        5, 6:          draft_line(1'b0, $urandom_range(3, 5));
        7:             draft_line(1'b1, $urandom_range(1, 2));
        8:             draft_put(slsre_pkg::CH_NEWLINE);
        default:       repeat ($urandom_range(1, 6)) draft_put(8'($urandom_range(0, 255)));
      endcase
    end
    // end marker on the closing newline, mid-line, or on a byte of its own
    case ($urandom_range(0, 3))
      0: if (draft_q.size() != 0) begin
        draft_q[draft_q.size() - 1].last = 1'b1;
        flush_draft();
      end else begin
        close_report(text_char());
      end
      1: begin
        if (draft_q.size() != 0 && draft_q[draft_q.size() - 1].ch == slsre_pkg::CH_NEWLINE)
          void'(draft_q.pop_back());
        close_report(text_char());
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       tail = slsre_pkg::CH_NEWLINE;
          1:       tail = slsre_pkg::CH_NUL;
          2:       tail = 8'(slsre_pkg::CH_DIGIT0 + $urandom_range(0, 9));
          default: tail = text_char();
        endcase
        close_report(tail);
      end
    endcase
  endtask

  task automatic run_phase(int n_words);
    int target;
    @(negedge clk_i);
    target = words_queued + n_words;
    while (words_queued < target) queue_report();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_line_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed reports on reset registers: empty ssid, any non-empty line matches
    draft_str("\n,a,b,,-1");
    close_report("7");                  // empty line skipped, empty field skipped
    draft_str("x,y");
    draft_put(slsre_pkg::CH_NUL);
    close_report("q");                  // too few fields, nul ends the content
    draft_str("q,r, +9999");
    close_report("9");                  // positive overflow clamps
    draft_str("a,b,-40000");
    close_report(slsre_pkg::CH_NEWLINE); // negative overflow, end on a newline
    close_report(slsre_pkg::CH_NUL);    // report of a lone nul
    draft_str("a,b,\t-");
    close_report("x");                  // sign without digits
    draft_str("z\n\na,b,c,9");
    close_report(8'hFF);                // first matching line decides with no field
    wait_drained();

    // short printable ssid
    program_ssid(random_name(4, 1'b1), 64'd4);
    run_phase(180);

    // full-width ssid, and the one long output hold-off while words keep coming
    program_ssid(random_name(SSID_SLOTS, 1'b1), 64'd32);
    pressure_on = 1'b1;
    run_phase(190);
    pressure_on = 1'b0;

    // all-ones registers, length past the cap so it counts as full width
    program_ssid({256{1'b1}}, 64'd45);
    run_phase(160);

    // write to an unmapped index is dropped; ssid with an embedded nul never matches
    cfg_write(REG_UNMAPPED, {64{1'b1}});
    begin
      logic [255:0] name;
      name = random_name(3, 1'b0);
      name[15:8] = slsre_pkg::CH_NUL;
      program_ssid(name, 64'd3);
    end
    run_phase(130);

    // all-zero registers, empty ssid
    program_ssid('0, 64'd0);
    run_phase(170);

    // single arbitrary byte
    program_ssid(random_name(1, 1'b0), 64'd1);
    run_phase(170);

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    program_ssid(random_name(2, 1'b1), 64'd2);
    run_phase(230);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
